[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[rtl/irclt_pkg.sv]
// ----------------------------------------------------------------------------
// irclt_pkg
// Types and constants shared by the IRC line tokenizer modules.
// ----------------------------------------------------------------------------
package irclt_pkg;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0] field_kind;
    logic [7:0] out_byte;
    logic [3:0] param_slot;
    logic       run_last;
    logic       prefix_valid;
    logic       command_present;
    logic [3:0] param_total;
    logic       overflow_flag;
  } out_item_t;

  // classified byte as held in the front queue
  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       crlf;
    logic       is_lf;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } head_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [1:0] KIND_PREFIX  = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_PARAM   = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef enum logic [7:0] {
    M_START        = 8'b0000_0001,
    M_PREFIX       = 8'b0000_0010,
    M_AFTER_PREFIX = 8'b0000_0100,
    M_COMMAND      = 8'b0000_1000,
    M_SEP          = 8'b0001_0000,
    M_PARAM        = 8'b0010_0000,
    M_TRAIL        = 8'b0100_0000,
    M_DROP         = 8'b1000_0000
  } mode_t;

  typedef enum logic [1:0] {
    ST_FEED    = 2'b01,
    ST_SUMMARY = 2'b10
  } back_st_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      return c - CASE_DIFF;
    end
    return c;
  endfunction

endpackage

[rtl/irclt_front.sv]
// ----------------------------------------------------------------------------
// irclt_front
// Accepts line bytes, marks CR/LF and end of line, and queues them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irclt_front (
  input  logic               clk,
  input  logic               rst,
  input  irclt_pkg::in_item_t item,
  input  logic               item_valid,
  output logic               item_stall,
  output irclt_pkg::head_t   head,
  input  logic               pop
);
  import irclt_pkg::*;

  q_entry_t          q [QUEUE_DEPTH];
  q_entry_t          entry_in;
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign item_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;

  always_comb begin
    entry_in.data  = item.line_byte;
    entry_in.eol   = item.end_of_line;
    entry_in.is_lf = (item.line_byte == CH_LF);
    entry_in.crlf  = (item.line_byte == CH_LF) || (item.line_byte == CH_CR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry_in;
    end
  end

  assign head.valid = (count != '0);
  assign head.entry = q[rd_ptr];

  `ASSERT_NEVER(a_queue_bound, count > QCNT_W'(QUEUE_DEPTH), "queue count past depth")
  `ASSERT_IMPL(a_pop_nonempty, pop |-> count != '0, "pop from empty queue")

endmodule

[rtl/irclt_back.sv]
// ----------------------------------------------------------------------------
// irclt_back
// Parser, CR/LF hold store and result register. One parser step per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irclt_back #(
  parameter int HOLD_DEPTH = 8,
  parameter int MAX_PARAMS = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  irclt_pkg::head_t    head,
  output logic                pop,
  output irclt_pkg::out_item_t result,
  output logic                result_valid,
  input  logic                result_stall
);
  import irclt_pkg::*;

  localparam int HCNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int PCNT_W = $clog2(MAX_PARAMS + 1);

  back_st_t              st, st_next;
  mode_t                 mode, mode_next;
  logic [PCNT_W-1:0]     param_count, param_count_next;
  logic [HCNT_W-1:0]     hold_count, hold_count_next;
  logic [HOLD_DEPTH-1:0] held_lf, held_lf_next;
  logic                  prefix_done, prefix_done_next;
  logic                  command_seen, command_seen_next;
  logic                  overflow_seen, overflow_seen_next;

  logic                  step;
  logic                  emit;
  out_item_t             emit_item;
  out_item_t             sum_item;

  // single parser step on feed_char
  logic [7:0]            feed_char;
  mode_t                 fd_mode;
  logic [PCNT_W-1:0]     fd_pc;
  logic                  fd_prefix, fd_cmd, fd_ovf, fd_emit;
  out_item_t             fd_item;

  assign step      = head.valid && (!result_valid || !result_stall);
  assign feed_char = (hold_count != '0) ? (held_lf[0] ? CH_LF : CH_CR) : head.entry.data;

  always_comb begin
    fd_mode   = mode;
    fd_pc     = param_count;
    fd_prefix = prefix_done;
    fd_cmd    = command_seen;
    fd_ovf    = overflow_seen;
    fd_emit   = 1'b0;
    fd_item   = '0;
    case (mode)
      M_START: begin
        fd_cmd = 1'b1;
        if (feed_char == CH_COLON) begin
          fd_cmd  = 1'b0;
          fd_mode = M_PREFIX;
        end else if (feed_char == CH_SPACE) begin
          fd_mode = M_SEP;
        end else begin
          fd_mode             = M_COMMAND;
          fd_emit             = 1'b1;
          fd_item.field_kind  = KIND_COMMAND;
          fd_item.out_byte    = upcase(feed_char);
        end
      end
      M_PREFIX: begin
        if (feed_char == CH_SPACE) begin
          fd_prefix = 1'b1;
          fd_mode   = M_AFTER_PREFIX;
        end else begin
          fd_emit            = 1'b1;
          fd_item.field_kind = KIND_PREFIX;
          fd_item.out_byte   = feed_char;
        end
      end
      M_AFTER_PREFIX: begin
        if (feed_char != CH_SPACE) begin
          fd_cmd             = 1'b1;
          fd_mode            = M_COMMAND;
          fd_emit            = 1'b1;
          fd_item.field_kind = KIND_COMMAND;
          fd_item.out_byte   = upcase(feed_char);
        end
      end
      M_COMMAND: begin
        if (feed_char == CH_SPACE) begin
          fd_mode = M_SEP;
        end else begin
          fd_emit            = 1'b1;
          fd_item.field_kind = KIND_COMMAND;
          fd_item.out_byte   = upcase(feed_char);
        end
      end
      M_SEP: begin
        if (feed_char != CH_SPACE) begin
          if (param_count >= PCNT_W'(MAX_PARAMS)) begin
            fd_ovf  = 1'b1;
            fd_mode = M_DROP;
          end else begin
            fd_pc = param_count + 1'b1;
            if (feed_char == CH_COLON) begin
              fd_mode = M_TRAIL;
            end else begin
              fd_mode            = M_PARAM;
              fd_emit            = 1'b1;
              fd_item.field_kind = KIND_PARAM;
              fd_item.out_byte   = feed_char;
              fd_item.param_slot = 4'(param_count);
            end
          end
        end
      end
      M_PARAM: begin
        if (feed_char == CH_SPACE) begin
          fd_mode = M_SEP;
        end else begin
          fd_emit            = 1'b1;
          fd_item.field_kind = KIND_PARAM;
          fd_item.out_byte   = feed_char;
          fd_item.param_slot = 4'(param_count - 1'b1);
        end
      end
      M_TRAIL: begin
        fd_emit            = 1'b1;
        fd_item.field_kind = KIND_PARAM;
        fd_item.out_byte   = feed_char;
        fd_item.param_slot = 4'(param_count - 1'b1);
      end
      default: begin
        fd_mode = mode;
      end
    endcase
  end

  // an unterminated prefix voids the prefix, command and parameter count of the summary
  always_comb begin
    sum_item                 = '0;
    sum_item.field_kind      = KIND_SUMMARY;
    sum_item.run_last        = 1'b1;
    sum_item.prefix_valid    = prefix_done && (mode != M_PREFIX);
    sum_item.command_present = command_seen && (mode != M_PREFIX);
    sum_item.param_total     = (mode == M_PREFIX) ? 4'd0 : 4'(param_count);
    sum_item.overflow_flag   = overflow_seen;
  end

  always_comb begin
    st_next            = st;
    mode_next          = mode;
    param_count_next   = param_count;
    hold_count_next    = hold_count;
    held_lf_next       = held_lf;
    prefix_done_next   = prefix_done;
    command_seen_next  = command_seen;
    overflow_seen_next = overflow_seen;
    pop                = 1'b0;
    emit               = 1'b0;
    emit_item          = fd_item;
    if (step) begin
      case (st)
        ST_FEED: begin
          if (head.entry.crlf && !head.entry.eol) begin
            pop = 1'b1;
            if (hold_count < HCNT_W'(HOLD_DEPTH)) begin
              for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (hold_count == HCNT_W'(i)) begin
                  held_lf_next[i] = head.entry.is_lf;
                end
              end
              hold_count_next = hold_count + 1'b1;
            end else begin
              overflow_seen_next = 1'b1;
            end
          end else if (head.entry.crlf) begin
            // CR/LF on the last byte: held bytes are discarded
            pop                = 1'b1;
            emit               = 1'b1;
            emit_item          = sum_item;
            mode_next          = M_START;
            param_count_next   = '0;
            hold_count_next    = '0;
            prefix_done_next   = 1'b0;
            command_seen_next  = 1'b0;
            overflow_seen_next = 1'b0;
          end else begin
            mode_next          = fd_mode;
            param_count_next   = fd_pc;
            prefix_done_next   = fd_prefix;
            command_seen_next  = fd_cmd;
            overflow_seen_next = fd_ovf;
            emit               = fd_emit;
            if (hold_count != '0) begin
              hold_count_next = hold_count - 1'b1;
              held_lf_next    = held_lf >> 1;
            end else if (head.entry.eol) begin
              st_next = ST_SUMMARY;
            end else begin
              pop = 1'b1;
            end
          end
        end
        ST_SUMMARY: begin
          pop                = 1'b1;
          emit               = 1'b1;
          emit_item          = sum_item;
          st_next            = ST_FEED;
          mode_next          = M_START;
          param_count_next   = '0;
          hold_count_next    = '0;
          prefix_done_next   = 1'b0;
          command_seen_next  = 1'b0;
          overflow_seen_next = 1'b0;
        end
        default: begin
          st_next = ST_FEED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_FEED;
      mode          <= M_START;
      param_count   <= '0;
      hold_count    <= '0;
      prefix_done   <= 1'b0;
      command_seen  <= 1'b0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      st            <= st_next;
      mode          <= mode_next;
      param_count   <= param_count_next;
      hold_count    <= hold_count_next;
      prefix_done   <= prefix_done_next;
      command_seen  <= command_seen_next;
      overflow_seen <= overflow_seen_next;
      if (step && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_lf <= held_lf_next;
    if (step && emit) begin
      result <= emit_item;
    end
  end

  `ASSERT_NEVER(a_hold_bound, hold_count > HCNT_W'(HOLD_DEPTH), "hold count past depth")
  `ASSERT_IMPL(a_sum_head, st == ST_SUMMARY |-> head.valid && head.entry.eol && !head.entry.crlf, "summary state without closing byte")
  `ASSERT_IMPL(a_sum_clear, step && st == ST_SUMMARY |=> hold_count == '0 && mode == M_START && param_count == '0, "line state not cleared after summary")

endmodule

[rtl/irc_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Streaming IRC line tokenizer: tags prefix, command and parameter bytes and
// closes each line with a summary transfer.
// ----------------------------------------------------------------------------
//   channel   dir   payload      handshake
//   item      in    in_item_t    item_valid / item_stall
//   result    out   out_item_t   result_valid / result_stall
//
// A parser step takes one byte: a mid-line CR/LF enters the hold store, held
// CR/LFs are released one per step before the next ordinary byte, and a
// summary step follows the final byte. The parser makes one step and at most
// one result transfer per cycle when not stalled, behind a two-entry queue.
// Reset clears all control state at once; the hold store has no reset.
// result_stall holds the parser; item_stall rises when the queue is full.

module irc_line_tokenizer #(
  parameter int HOLD_DEPTH = 8,
  parameter int MAX_PARAMS = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  irclt_pkg::in_item_t  item,
  input  logic                 item_valid,
  output logic                 item_stall,
  output irclt_pkg::out_item_t result,
  output logic                 result_valid,
  input  logic                 result_stall
);
  import irclt_pkg::*;

  head_t head;
  logic  pop;

  irclt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .head       (head),
    .pop        (pop)
  );

  irclt_back #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
